[hw/rtl/sidasc_pkg.sv]
// Package for the signed integer to decimal ASCII converter.
// Holds default sizes, ASCII codes, the back-end state type and the digit encoder.
// No dependencies.
package sidasc_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_DIGITS_DEF = 10;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_MINUS = 8'd45;

    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    typedef logic [7:0] t_char;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_DIGIT
    } t_back_state;

    function automatic t_char digit_to_ascii(input logic [3:0] digit);
        digit_to_ascii = ASCII_ZERO + {4'd0, digit};
    endfunction

endpackage

[hw/rtl/sidasc_if.sv]
// Stream interfaces for the converter: integer input channel and character output channel.
// Each carries valid, ready and its payload. Depends on sidasc_pkg.
interface sidasc_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sidasc_out_if;
    import sidasc_pkg::*;
    logic  valid;
    logic  ready;
    t_char text_char;
    logic  last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

[hw/rtl/sidasc_front.sv]
// Front end: accepts integers, splits each into sign and unsigned magnitude.
// Feeds the job queue. Depends on sidasc_pkg and sidasc_in_if.
module sidasc_front
    import sidasc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    sidasc_in_if.sink              i_in,
    output logic                   o_push_valid,
    output logic [VALUE_BITS:0]    o_push_data,
    input  logic                   i_push_ready
);

    logic                  lc_neg;
    logic [VALUE_BITS-1:0] lc_raw;
    logic [VALUE_BITS-1:0] lc_mag;

    always_comb begin
        lc_raw = VALUE_BITS'(i_in.value);
        lc_neg = lc_raw[VALUE_BITS-1];
        lc_mag = lc_neg ? (~lc_raw + VALUE_BITS'(1)) : lc_raw;
    end

    assign o_push_valid = i_in.valid;
    assign o_push_data  = {lc_neg, lc_mag};
    assign i_in.ready   = i_push_ready;

endmodule

[hw/rtl/sidasc_queue.sv]
// Short job queue between the front end and the conversion back end.
// Register-based FIFO with a fill count. Depends on sidasc_pkg.
module sidasc_queue
    import sidasc_pkg::*;
#(
    parameter int WIDTH = VALUE_BITS_DEF + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output logic [WIDTH-1:0] o_pop_data,
    input  logic             i_pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             lc_push, lc_pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign lc_push      = i_push_valid && o_push_ready;
    assign lc_pop       = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (lc_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (lc_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (lc_push && !lc_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (lc_pop && !lc_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lc_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

[hw/rtl/sidasc_back.sv]
// Back end: shift-and-add-3 binary to BCD, one bit per cycle, then character emission.
// Registered output stage. Depends on sidasc_pkg and sidasc_out_if.
module sidasc_back
    import sidasc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pop_valid,
    input  logic [VALUE_BITS:0] i_pop_data,
    output logic                o_pop_ready,
    sidasc_out_if.source        o_out
);

    localparam int BCD_W  = MAX_DIGITS * 4;
    localparam int IDX_W  = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W = $clog2(VALUE_BITS);

    t_back_state           r_state, n_state;
    logic [VALUE_BITS-1:0] r_shift, n_shift;
    logic [BCD_W-1:0]      r_bcd, n_bcd;
    logic                  r_neg, n_neg;
    logic                  r_ovf, n_ovf;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [IDX_W-1:0]      r_pos, n_pos;
    logic [STEP_W-1:0]     r_step, n_step;
    logic                  r_ovalid, n_ovalid;
    t_char                 r_char, n_char;
    logic                  r_last, n_last;

    logic [BCD_W-1:0]      lc_adj;
    logic [BCD_W-1:0]      lc_bcd_sh;
    logic                  lc_carry;
    logic [IDX_W-1:0]      lc_cnt_idx;
    logic                  lc_grow;
    logic [CNT_W-1:0]      lc_cnt_next;
    logic [3:0]            lc_digit;
    logic                  lc_free;

    always_comb begin
        lc_adj = r_bcd;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (r_bcd[i*4 +: 4] >= BCD_ADJ_MIN) begin
                lc_adj[i*4 +: 4] = r_bcd[i*4 +: 4] + BCD_ADJ;
            end
        end
        lc_carry    = lc_adj[BCD_W-1];
        lc_bcd_sh   = {lc_adj[BCD_W-2:0], r_shift[VALUE_BITS-1]};
        lc_cnt_idx  = r_cnt[IDX_W-1:0];
        lc_grow     = (r_cnt < CNT_W'(MAX_DIGITS)) && (lc_bcd_sh[lc_cnt_idx*4 +: 4] != '0);
        lc_cnt_next = lc_grow ? r_cnt + CNT_W'(1) : r_cnt;
        lc_digit    = r_bcd[r_pos*4 +: 4];
        lc_free     = !r_ovalid || o_out.ready;
    end

    always_comb begin
        n_state     = r_state;
        n_shift     = r_shift;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_ovf       = r_ovf;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_step      = r_step;
        n_ovalid    = r_ovalid && !o_out.ready;
        n_char      = r_char;
        n_last      = r_last;
        o_pop_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_neg   = i_pop_data[VALUE_BITS];
                    n_shift = i_pop_data[VALUE_BITS-1:0];
                    n_bcd   = '0;
                    n_ovf   = 1'b0;
                    n_cnt   = CNT_W'(1);
                    n_step  = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_bcd   = lc_bcd_sh;
                n_shift = {r_shift[VALUE_BITS-2:0], 1'b0};
                n_ovf   = r_ovf || lc_carry;
                n_cnt   = lc_cnt_next;
                n_step  = r_step + STEP_W'(1);
                if (r_step == STEP_W'(VALUE_BITS - 1)) begin
                    n_pos   = (r_ovf || lc_carry) ? IDX_W'(MAX_DIGITS - 1)
                                                  : IDX_W'(lc_cnt_next - CNT_W'(1));
                    n_state = r_neg ? ST_SIGN : ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (lc_free) begin
                    n_ovalid = 1'b1;
                    n_char   = ASCII_MINUS;
                    n_last   = 1'b0;
                    n_state  = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (lc_free) begin
                    n_ovalid = 1'b1;
                    n_char   = digit_to_ascii(lc_digit);
                    n_last   = (r_pos == '0);
                    if (r_pos == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos = r_pos - IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_neg   <= n_neg;
        r_ovf   <= n_ovf;
        r_cnt   <= n_cnt;
        r_pos   <= n_pos;
        r_step  <= n_step;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.text_char = r_char;
    assign o_out.last_char = r_last;

endmodule

[hw/rtl/signed_int_to_decimal_ascii.sv]
// Top level of the signed integer to decimal ASCII converter.
// Instantiates sidasc_front, sidasc_queue and sidasc_back. Depends on sidasc_pkg, sidasc_if.
//
//   channel  dir  payload                     role
//   i_in     in   value[VALUE_BITS-1:0] s     integer to convert
//   o_out    out  text_char[7:0], last_char   one character per transfer, MSD first
//
// Each item leaves the queue, is converted by shift-and-add-3 over its VALUE_BITS bits
// in the back end, then is emitted as up to MAX_DIGITS+1 characters, sign first.
// The queue holds two further items while a conversion runs; a stalled output
// holds its character and stops emission only. Reset clears queue and back-end state.
module signed_int_to_decimal_ascii
    import sidasc_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sidasc_in_if.sink    i_in,
    sidasc_out_if.source o_out
);

    logic                push_valid;
    logic [VALUE_BITS:0] push_data;
    logic                push_ready;
    logic                pop_valid;
    logic [VALUE_BITS:0] pop_data;
    logic                pop_ready;

    sidasc_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    sidasc_queue #(
        .WIDTH (VALUE_BITS + 1)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    sidasc_back #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

[hw/rtl/sidasc_checker.sv]
// Port-level checker for the converter's character stream, with its bind to the top level.
// Depends on sidasc_pkg.
module sidasc_checker
    import sidasc_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_out_valid,
    input logic  i_out_ready,
    input t_char i_out_char,
    input logic  i_out_last
);

    logic r_in_run;
    logic r_first_digit;
    logic lc_xfer;

    assign lc_xfer = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run      <= 1'b0;
            r_first_digit <= 1'b1;
        end else if (lc_xfer) begin
            r_in_run      <= !i_out_last;
            r_first_digit <= i_out_last || (i_out_char == ASCII_MINUS);
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("output changed while stalled");

    a_charset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_char == ASCII_MINUS) ||
                        ((i_out_char >= ASCII_ZERO) && (i_out_char <= ASCII_ZERO + 8'd9)))
        else $error("character outside sign and digits");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_char == ASCII_MINUS) |-> !i_out_last)
        else $error("minus sign ends a run");

    a_minus_leads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_in_run |-> (i_out_char != ASCII_MINUS))
        else $error("minus sign inside a run");

    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_first_digit && (i_out_char == ASCII_ZERO) |-> i_out_last)
        else $error("leading zero emitted");

endmodule

bind signed_int_to_decimal_ascii sidasc_checker u_sidasc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.text_char),
    .i_out_last  (o_out.last_char)
);
